// File: rtl/fgt_pkg.sv
// fgt_pkg: types, constants and helper functions for the fuzzy gain tuner
// membership shapes, the 7x7 kp rule base and the defuzzification numerators
// no dependencies
package fgt_pkg;

    localparam int OUT_W   = 16;
    localparam int X_W     = 12;
    localparam int DEG_W   = 16;
    localparam int NSETS   = 7;

    typedef logic [DEG_W-1:0]        deg_t;
    typedef logic signed [X_W-1:0]   fx_t;
    typedef logic [2:0]              lbl_t;
    typedef logic signed [19:0]      dnum_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_INPUT_SCALE = 2'd0,
        REG_RATE_SCALE  = 2'd1,
        REG_ERROR_BIAS  = 2'd2
    } reg_idx_t;

    // fuzzy set labels
    localparam lbl_t SET_NB = 3'd0;
    localparam lbl_t SET_NM = 3'd1;
    localparam lbl_t SET_NS = 3'd2;
    localparam lbl_t SET_ZO = 3'd3;
    localparam lbl_t SET_PS = 3'd4;
    localparam lbl_t SET_PM = 3'd5;
    localparam lbl_t SET_PB = 3'd6;

    localparam int   X_SAT   = 1024;     // 4.0 in Q7.8
    localparam deg_t DEG_ONE = 16'd32768;
    localparam int   OUT_LIM = 16384;    // 0.5 in Q1.15

    // divide by 20 as floor(floor(n/4)/5), the /5 by reciprocal multiply
    localparam int DIV5_OFFSET = 50000;  // 5 * Q_OFFSET keeps the operand positive
    localparam int Q_OFFSET    = 10000;
    localparam int RECIP_MUL   = 209716; // ceil(2^20 / 5)
    localparam int RECIP_SHIFT = 20;
    localparam int ROUND_ADD   = 10;

    // kp rule base, row = e set, column = ec set
    localparam lbl_t KP_RULES [NSETS][NSETS] = '{
        '{SET_PB, SET_PB, SET_PM, SET_PM, SET_PS, SET_ZO, SET_ZO},
        '{SET_PB, SET_PB, SET_PM, SET_PS, SET_PS, SET_ZO, SET_ZO},
        '{SET_PM, SET_PM, SET_PM, SET_PS, SET_ZO, SET_NS, SET_NS},
        '{SET_PM, SET_PM, SET_PS, SET_ZO, SET_NS, SET_NM, SET_NM},
        '{SET_PS, SET_PS, SET_ZO, SET_NS, SET_NS, SET_NM, SET_NM},
        '{SET_PS, SET_ZO, SET_NS, SET_NM, SET_NM, SET_NM, SET_NB},
        '{SET_ZO, SET_ZO, SET_NM, SET_NM, SET_NM, SET_NB, SET_NB}
    };

    // triangle with breakpoints in Q7.8, slopes as shifts (span 256 -> 7, 512 -> 6)
    function automatic deg_t tri_deg(int x, int a, int b, int c, int sl, int sr);
        deg_t r;
        if (x <= a)      r = '0;
        else if (x <= b) r = DEG_W'((x - a) <<< sl);
        else if (x <= c) r = DEG_W'((c - x) <<< sr);
        else             r = '0;
        return r;
    endfunction

    // membership degree of x in set s
    function automatic deg_t fz_degree(lbl_t s, fx_t xv);
        int   x;
        deg_t r;
        x = int'(xv);
        case (s)
            SET_NB: begin
                if (x <= -768)      r = DEG_ONE;
                else if (x <= -256) r = DEG_W'((-256 - x) <<< 6);
                else                r = '0;
            end
            SET_NM: r = tri_deg(x, -768, -512, 0, 7, 6);
            SET_NS: r = tri_deg(x, -768, -256, 256, 6, 6);
            SET_ZO: r = tri_deg(x, -512, 0, 512, 6, 6);
            SET_PS: r = tri_deg(x, -256, 256, 768, 6, 6);
            SET_PM: r = tri_deg(x, 0, 512, 768, 6, 7);
            SET_PB: begin
                if (x <= 256)     r = '0;
                else if (x < 768) r = DEG_W'((x - 256) <<< 6);
                else              r = DEG_ONE;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // defuzzification numerator, twenty times the output in Q1.15 units
    function automatic dnum_t defuzz_num(lbl_t l, deg_t d);
        int dv;
        int n;
        dv = int'(d);
        case (l)
            SET_NB:  n = -65536 - 4 * dv;
            SET_NM:  n = -98304 - dv;
            SET_NS:  n = -65536;
            SET_ZO:  n = 0;
            SET_PS:  n = 65536;
            SET_PM:  n = 98304 + dv;
            SET_PB:  n = 65536 + 4 * dv;
            default: n = 0;
        endcase
        return 20'(n);
    endfunction

endpackage

// File: rtl/fuzzy_pid_gain_tuner.sv
// fuzzy_pid_gain_tuner: fuzzy self-tuning kp correction, fully pipelined
// depends on fgt_pkg
//
// Usage:
//   Input channel s_valid/s_ready carries error_now and error_prev (signed Q7.8).
//   Result channel m_valid/m_ready carries gain_delta (signed Q1.15, within +-0.5),
//   one result per input transaction, in order.
//   Configuration channel cfg_valid/cfg_ready with cfg_index/cfg_data writes
//   input_scale (0), rate_scale (1), error_bias (2); other indexes are ignored.
//   cfg_ready is always high. Write configuration only with the pipeline empty.
//   A zero scale acts as a raw scale value of one (1/256).
// Throughput: one transaction per cycle while the receiver does not stall.
// The depth comes from the input register and the two restoring dividers, one
//   quotient bit per stage over DATA_WIDTH + 9 stages, followed by saturate,
//   fuzzify, row search, rule select, numerator, multiply and output.
// Reset (aresetn low, synchronous) empties every stage and restores the scales
//   to 1.0 and the bias to 0.
// When the receiver stalls, each stage holds once its successor is full; empty
//   stages keep filling, so s_ready falls only when every stage holds data.
module fuzzy_pid_gain_tuner #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [DATA_WIDTH-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [DATA_WIDTH-1:0]  s_error_now,
    input  logic signed [DATA_WIDTH-1:0]  s_error_prev,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [fgt_pkg::OUT_W-1:0] m_gain_delta
);
    import fgt_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int NB   = DW + 9;          // numerator width and divider stages
    localparam int EW   = NB + 2;          // signed width ahead of saturation
    localparam int S_SAT = NB + 1;
    localparam int S_DEG = NB + 2;
    localparam int S_ROW = NB + 3;
    localparam int S_SEL = NB + 4;
    localparam int S_NUM = NB + 5;
    localparam int S_MUL = NB + 6;
    localparam int S_OUT = NB + 7;
    localparam int NS    = NB + 8;
    localparam int YW    = 17;
    localparam int PW    = YW + 18;

    // configuration registers
    logic [DW-1:0] input_scale_reg;
    logic [DW-1:0] rate_scale_reg;
    logic [DW-1:0] error_bias_reg;
    logic [DW-1:0] div_e;
    logic [DW-1:0] div_c;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_scale_reg <= DW'(256);
            rate_scale_reg  <= DW'(256);
            error_bias_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INPUT_SCALE: input_scale_reg <= cfg_data;
                REG_RATE_SCALE:  rate_scale_reg  <= cfg_data;
                REG_ERROR_BIAS:  error_bias_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign div_e = (input_scale_reg == '0) ? DW'(1) : input_scale_reg;
    assign div_c = (rate_scale_reg == '0) ? DW'(1) : rate_scale_reg;

    // stage valids and per-stage enables, a stage loads when empty or moving on
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // divider pipeline payload, index 0 is the input register
    logic [NB-1:0] num_e_reg [0:NB];
    logic [NB-1:0] num_c_reg [0:NB];
    logic [DW-1:0] rem_e_reg [0:NB];
    logic [DW-1:0] rem_c_reg [0:NB];
    logic [NB-1:0] q_e_reg   [0:NB];
    logic [NB-1:0] q_c_reg   [0:NB];
    logic          neg_c_reg [0:NB];

    // input stage: magnitudes of the error and of the error change
    logic signed [DW:0] e1_ext;
    logic signed [DW:0] diff;
    logic [DW:0]        mag_e;
    logic [DW:0]        mag_c;

    assign e1_ext = (DW+1)'(s_error_now);
    assign diff   = e1_ext - (DW+1)'(s_error_prev);
    assign mag_e  = e1_ext[DW] ? (DW+1)'(-e1_ext) : (DW+1)'(e1_ext);
    assign mag_c  = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            num_e_reg[0] <= {mag_e, 8'd0};
            num_c_reg[0] <= {mag_c, 8'd0};
            rem_e_reg[0] <= '0;
            rem_c_reg[0] <= '0;
            q_e_reg[0]   <= '0;
            q_c_reg[0]   <= '0;
            neg_c_reg[0] <= diff[DW];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 1; k <= NB; k++) begin : g_div
        logic [DW:0] trial_e;
        logic [DW:0] trial_c;
        logic        bit_e;
        logic        bit_c;

        assign trial_e = {rem_e_reg[k-1], num_e_reg[k-1][NB-1]};
        assign trial_c = {rem_c_reg[k-1], num_c_reg[k-1][NB-1]};
        assign bit_e   = trial_e >= {1'b0, div_e};
        assign bit_c   = trial_c >= {1'b0, div_c};

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                num_e_reg[k] <= {num_e_reg[k-1][NB-2:0], 1'b0};
                num_c_reg[k] <= {num_c_reg[k-1][NB-2:0], 1'b0};
                rem_e_reg[k] <= bit_e ? DW'(trial_e - {1'b0, div_e}) : DW'(trial_e);
                rem_c_reg[k] <= bit_c ? DW'(trial_c - {1'b0, div_c}) : DW'(trial_c);
                q_e_reg[k]   <= {q_e_reg[k-1][NB-2:0], bit_e};
                q_c_reg[k]   <= {q_c_reg[k-1][NB-2:0], bit_c};
                neg_c_reg[k] <= neg_c_reg[k-1];
            end
        end
    end

    // saturate e and ec to the fuzzy universe
    logic signed [EW-1:0] e_full;
    logic signed [EW-1:0] ec_full;
    fx_t                  e_sat;
    fx_t                  ec_sat;
    fx_t                  e_reg;
    fx_t                  ec_reg;

    assign e_full  = EW'($signed(error_bias_reg)) - $signed({2'b00, q_e_reg[NB]});
    assign ec_full = neg_c_reg[NB] ? -$signed({2'b00, q_c_reg[NB]})
                                   :  $signed({2'b00, q_c_reg[NB]});

    always_comb begin
        if (e_full < -EW'(X_SAT))      e_sat = -X_W'(X_SAT);
        else if (e_full > EW'(X_SAT))  e_sat = X_W'(X_SAT);
        else                           e_sat = X_W'(e_full);
        if (ec_full < -EW'(X_SAT))     ec_sat = -X_W'(X_SAT);
        else if (ec_full > EW'(X_SAT)) ec_sat = X_W'(X_SAT);
        else                           ec_sat = X_W'(ec_full);
    end

    always_ff @(posedge aclk) begin
        if (en[S_SAT]) begin
            e_reg  <= e_sat;
            ec_reg <= ec_sat;
        end
    end

    // fuzzify both inputs into seven degrees each
    deg_t de_reg [NSETS];
    deg_t dc_reg [NSETS];

    always_ff @(posedge aclk) begin
        if (en[S_DEG]) begin
            for (int i = 0; i < NSETS; i++) begin
                de_reg[i] <= fz_degree(3'(i), e_reg);
                dc_reg[i] <= fz_degree(3'(i), ec_reg);
            end
        end
    end

    // per row: rule strengths and the first strongest column
    deg_t row_best_reg [NSETS];
    lbl_t row_col_reg  [NSETS];
    deg_t row_best     [NSETS];
    lbl_t row_col      [NSETS];

    always_comb begin
        for (int i = 0; i < NSETS; i++) begin
            row_best[i] = (de_reg[i] < dc_reg[0]) ? de_reg[i] : dc_reg[0];
            row_col[i]  = SET_NB;
            for (int j = 1; j < NSETS; j++) begin
                if (((de_reg[i] < dc_reg[j]) ? de_reg[i] : dc_reg[j]) > row_best[i]) begin
                    row_best[i] = (de_reg[i] < dc_reg[j]) ? de_reg[i] : dc_reg[j];
                    row_col[i]  = 3'(j);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[S_ROW]) begin
            row_best_reg <= row_best;
            row_col_reg  <= row_col;
        end
    end

    // across rows: winning rule and its kp label
    deg_t best;
    lbl_t best_row;
    deg_t best_reg;
    lbl_t label_reg;

    always_comb begin
        best     = row_best_reg[0];
        best_row = SET_NB;
        for (int i = 1; i < NSETS; i++) begin
            if (row_best_reg[i] > best) begin
                best     = row_best_reg[i];
                best_row = 3'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[S_SEL]) begin
            best_reg  <= best;
            label_reg <= KP_RULES[best_row][row_col_reg[best_row]];
        end
    end

    // numerator plus rounding, divided by four, offset to stay positive
    dnum_t         num_rnd;
    dnum_t         num_q4;
    logic [YW-1:0] y_reg;

    assign num_rnd = defuzz_num(label_reg, best_reg) + 20'(ROUND_ADD);
    assign num_q4  = num_rnd >>> 2;

    always_ff @(posedge aclk) begin
        if (en[S_NUM]) begin
            y_reg <= YW'(num_q4 + 20'(DIV5_OFFSET));
        end
    end

    // reciprocal multiply for the divide by five
    logic [PW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en[S_MUL]) begin
            prod_reg <= PW'(y_reg) * PW'(RECIP_MUL);
        end
    end

    // remove the offset, clamp and register the result
    logic signed [OUT_W:0]   r_full;
    logic signed [OUT_W-1:0] r_clamp;
    logic signed [OUT_W-1:0] out_reg;

    assign r_full = $signed({2'b00, prod_reg[PW-1:RECIP_SHIFT]}) - (OUT_W+1)'(Q_OFFSET);

    always_comb begin
        if (r_full < -(OUT_W+1)'(OUT_LIM))     r_clamp = -OUT_W'(OUT_LIM);
        else if (r_full > (OUT_W+1)'(OUT_LIM)) r_clamp = OUT_W'(OUT_LIM);
        else                                   r_clamp = OUT_W'(r_full);
    end

    always_ff @(posedge aclk) begin
        if (en[S_OUT]) begin
            out_reg <= r_clamp;
        end
    end

    assign m_valid      = v_reg[S_OUT];
    assign m_gain_delta = out_reg;

    // checks
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> (v_reg == '0))
        else $error("pipeline not empty after reset");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gain_delta <= OUT_W'(OUT_LIM) && m_gain_delta >= -OUT_W'(OUT_LIM)))
        else $error("gain_delta out of range");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && (&v_reg)) |-> !s_ready)
        else $error("input accepted into a full stalled pipeline");

    a_bubble_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[0] |-> s_ready)
        else $error("input refused with an empty first stage");

endmodule
